### rtl/core/assert_macros.svh
// Concurrent assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked at every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

### rtl/core/trla_pkg.sv
`timescale 1ns / 1ps

package trla_pkg;

   localparam int RIDER_W    = 8;
   localparam int STATION_W  = 4;
   localparam int ROUTE_W    = 2 * STATION_W;
   localparam int TIME_W     = 24;
   localparam int FRAC_W     = 8;
   localparam int SUM_W      = 48;
   localparam int SUM_EXT_W  = SUM_W + 1;
   localparam int COUNT_W    = 32;
   localparam int AVG_W      = 32;
   localparam int RECORD_W   = STATION_W + TIME_W;
   localparam int NUM_RIDERS = 1 << RIDER_W;
   localparam int NUM_ROUTES = 1 << ROUTE_W;
   localparam int DIVIDEND_W = SUM_W + FRAC_W;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
   localparam int REQ_DATA_W = RIDER_W + 2 * STATION_W + TIME_W;
   localparam int FUNC_W     = 2;
   localparam int RSP_USER_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CHECK_IN  = 2'd0,
      FUNC_CHECK_OUT = 2'd1,
      FUNC_QUERY     = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RIDER,
      S_ROUTE,
      S_DIV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                 rd_en;
      logic                 wr_en;
      logic                 clr_en;
      logic [RIDER_W-1:0]   addr;
      logic [STATION_W-1:0] station;
      logic [TIME_W-1:0]    stamp;
   } rider_cmd_type;

   typedef struct packed {
      logic                 valid;
      logic [STATION_W-1:0] station;
      logic [TIME_W-1:0]    stamp;
   } rider_data_type;

   typedef struct packed {
      logic               rd_en;
      logic               wr_en;
      logic [ROUTE_W-1:0] addr;
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
   } route_cmd_type;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
   } route_data_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [COUNT_W-1:0]    divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_res_type;

endpackage

### rtl/core/trla_rider_table.sv
`timescale 1ns / 1ps

module trla_rider_table (
   input  logic                     clock,
   input  logic                     reset,
   input  trla_pkg::rider_cmd_type  cmd,
   output trla_pkg::rider_data_type data
);

   logic [trla_pkg::NUM_RIDERS-1:0] valid_ff;
   logic [trla_pkg::NUM_RIDERS-1:0] valid_in;
   logic [trla_pkg::RECORD_W-1:0]   mem [trla_pkg::NUM_RIDERS];
   logic [trla_pkg::RECORD_W-1:0]   rd_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[cmd.addr] = 1'b1;
      end else if (cmd.clr_en) begin
         valid_in[cmd.addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= {cmd.station, cmd.stamp};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.addr];
      end
   end

   // valid is looked up at the live address; record comes from the read register
   assign data.valid   = valid_ff[cmd.addr];
   assign data.station = rd_ff[trla_pkg::RECORD_W-1:trla_pkg::TIME_W];
   assign data.stamp   = rd_ff[trla_pkg::TIME_W-1:0];

endmodule

### rtl/core/trla_route_table.sv
`timescale 1ns / 1ps

module trla_route_table (
   input  logic                     clock,
   input  logic                     reset,
   input  trla_pkg::route_cmd_type  cmd,
   output trla_pkg::route_data_type data
);

   localparam int ENTRY_W = trla_pkg::SUM_W + trla_pkg::COUNT_W;

   logic [trla_pkg::NUM_ROUTES-1:0] valid_ff;
   logic [trla_pkg::NUM_ROUTES-1:0] valid_in;
   logic [ENTRY_W-1:0]              mem [trla_pkg::NUM_ROUTES];
   logic [ENTRY_W-1:0]              rd_ff;
   logic                            rd_valid_ff;
   logic                            rd_valid_in;

   always_comb begin
      valid_in    = valid_ff;
      rd_valid_in = rd_valid_ff;
      if (cmd.wr_en) begin
         valid_in[cmd.addr] = 1'b1;
      end
      if (cmd.rd_en) begin
         rd_valid_in = valid_ff[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= {cmd.sum, cmd.count};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.addr];
      end
   end

   // never-written routes read as zero
   assign data.sum   = rd_valid_ff ? rd_ff[ENTRY_W-1:trla_pkg::COUNT_W] : '0;
   assign data.count = rd_valid_ff ? rd_ff[trla_pkg::COUNT_W-1:0] : '0;

endmodule

### rtl/core/trla_divider.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module trla_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  trla_pkg::div_cmd_type cmd,
   output trla_pkg::div_res_type res
);

   localparam logic [trla_pkg::DIV_CNT_W-1:0] LAST_STEP =
      trla_pkg::DIV_CNT_W'(trla_pkg::DIVIDEND_W - 1);

   logic                               busy_ff;
   logic                               busy_in;
   logic                               done_ff;
   logic                               done_in;
   logic [trla_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic [trla_pkg::DIV_CNT_W-1:0]     cnt_in;
   logic [trla_pkg::COUNT_W-1:0]       rem_ff;
   logic [trla_pkg::COUNT_W-1:0]       rem_in;
   logic [trla_pkg::DIVIDEND_W-1:0]    quo_ff;
   logic [trla_pkg::DIVIDEND_W-1:0]    quo_in;
   logic [trla_pkg::COUNT_W-1:0]       dsr_ff;
   logic [trla_pkg::COUNT_W-1:0]       dsr_in;
   logic [trla_pkg::COUNT_W:0]         trial;
   logic [trla_pkg::COUNT_W:0]         diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[trla_pkg::DIVIDEND_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
      end else if (busy_ff) begin
         if (!diff[trla_pkg::COUNT_W]) begin
            rem_in = diff[trla_pkg::COUNT_W-1:0];
            quo_in = {quo_ff[trla_pkg::DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[trla_pkg::COUNT_W-1:0];
            quo_in = {quo_ff[trla_pkg::DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;

endmodule

### rtl/core/trip_latency_route_averager_core.sv
`timescale 1ns / 1ps
// States per word: check-out DECODE, RIDER, ROUTE, DONE (DECODE, DONE if no record);
// query DECODE, ROUTE, DIV, DONE (no DIV when no trips); others DECODE, DONE.
// Query time is set by the 56-step shift-subtract divider, one quotient bit per cycle.
// One word at a time; the next word is taken the cycle after a result is staged,
// even while that result still waits on rsp_tready.
// Reset: synchronous, clears rider and route valid bits at once; no clearing pass.

module trip_latency_route_averager_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rider_id[7:0], station[11:8], end_station[15:12], timestamp[39:16]
   input  logic [trla_pkg::REQ_DATA_W-1:0]     req_tdata,
   // func[1:0]
   input  logic [trla_pkg::FUNC_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // average[31:0]
   output logic [trla_pkg::AVG_W-1:0]          rsp_tdata,
   // route_found[0], rider_missing[1]
   output logic [trla_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   localparam int ST_LO = trla_pkg::RIDER_W;
   localparam int EN_LO = ST_LO + trla_pkg::STATION_W;
   localparam int TS_LO = EN_LO + trla_pkg::STATION_W;

   trla_pkg::state_type             state_ff;
   trla_pkg::state_type             state_in;
   trla_pkg::func_type              func_ff;
   trla_pkg::func_type              func_in;
   logic [trla_pkg::RIDER_W-1:0]    rider_ff;
   logic [trla_pkg::RIDER_W-1:0]    rider_in;
   logic [trla_pkg::STATION_W-1:0]  stn_ff;
   logic [trla_pkg::STATION_W-1:0]  stn_in;
   logic [trla_pkg::STATION_W-1:0]  endst_ff;
   logic [trla_pkg::STATION_W-1:0]  endst_in;
   logic [trla_pkg::TIME_W-1:0]     ts_ff;
   logic [trla_pkg::TIME_W-1:0]     ts_in;
   logic [trla_pkg::TIME_W-1:0]     dt_ff;
   logic [trla_pkg::TIME_W-1:0]     dt_in;
   logic [trla_pkg::AVG_W-1:0]      avg_ff;
   logic [trla_pkg::AVG_W-1:0]      avg_in;
   logic                            found_ff;
   logic                            found_in;
   logic                            missing_ff;
   logic                            missing_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [trla_pkg::AVG_W-1:0]      rsp_data_ff;
   logic [trla_pkg::AVG_W-1:0]      rsp_data_in;
   logic [trla_pkg::RSP_USER_W-1:0] rsp_user_ff;
   logic [trla_pkg::RSP_USER_W-1:0] rsp_user_in;
   logic [trla_pkg::SUM_EXT_W-1:0]  sum_ext;

   trla_pkg::rider_cmd_type  rider_cmd;
   trla_pkg::rider_data_type rider_data;
   trla_pkg::route_cmd_type  route_cmd;
   trla_pkg::route_data_type route_data;
   trla_pkg::div_cmd_type    div_cmd;
   trla_pkg::div_res_type    div_res;

   trla_rider_table u_rider (
      .clock (clock),
      .reset (reset),
      .cmd   (rider_cmd),
      .data  (rider_data)
   );

   trla_route_table u_route (
      .clock (clock),
      .reset (reset),
      .cmd   (route_cmd),
      .data  (route_data)
   );

   trla_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      rider_in     = rider_ff;
      stn_in       = stn_ff;
      endst_in     = endst_ff;
      ts_in        = ts_ff;
      dt_in        = dt_ff;
      avg_in       = avg_ff;
      found_in     = found_ff;
      missing_in   = missing_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      req_tready   = 1'b0;

      rider_cmd.rd_en   = 1'b0;
      rider_cmd.wr_en   = 1'b0;
      rider_cmd.clr_en  = 1'b0;
      rider_cmd.addr    = rider_ff;
      rider_cmd.station = stn_ff;
      rider_cmd.stamp   = ts_ff;

      sum_ext = trla_pkg::SUM_EXT_W'(route_data.sum) + trla_pkg::SUM_EXT_W'(dt_ff);

      route_cmd.rd_en = 1'b0;
      route_cmd.wr_en = 1'b0;
      route_cmd.addr  = {stn_ff, endst_ff};
      route_cmd.sum   = sum_ext[trla_pkg::SUM_EXT_W-1] ? '1 : sum_ext[trla_pkg::SUM_W-1:0];
      route_cmd.count = (&route_data.count) ? route_data.count
                                            : route_data.count + 1'b1;

      div_cmd.start    = 1'b0;
      div_cmd.dividend = {route_data.sum, {trla_pkg::FRAC_W{1'b0}}};
      div_cmd.divisor  = route_data.count;

      case (state_ff)
         trla_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in    = trla_pkg::func_type'(req_tuser);
               rider_in   = req_tdata[ST_LO-1:0];
               stn_in     = req_tdata[EN_LO-1:ST_LO];
               endst_in   = req_tdata[TS_LO-1:EN_LO];
               ts_in      = req_tdata[trla_pkg::REQ_DATA_W-1:TS_LO];
               avg_in     = '0;
               found_in   = 1'b0;
               missing_in = 1'b0;
               state_in   = trla_pkg::S_DECODE;
            end
         end
         trla_pkg::S_DECODE: begin
            case (func_ff)
               trla_pkg::FUNC_CHECK_IN: begin
                  rider_cmd.wr_en = 1'b1;
                  state_in        = trla_pkg::S_DONE;
               end
               trla_pkg::FUNC_CHECK_OUT: begin
                  if (rider_data.valid) begin
                     rider_cmd.rd_en = 1'b1;
                     state_in        = trla_pkg::S_RIDER;
                  end else begin
                     missing_in = 1'b1;
                     state_in   = trla_pkg::S_DONE;
                  end
               end
               trla_pkg::FUNC_QUERY: begin
                  route_cmd.rd_en = 1'b1;
                  state_in        = trla_pkg::S_ROUTE;
               end
               default: begin
                  state_in = trla_pkg::S_DONE;
               end
            endcase
         end
         trla_pkg::S_RIDER: begin
            rider_cmd.clr_en = 1'b1;
            dt_in            = ts_ff - rider_data.stamp;
            route_cmd.rd_en  = 1'b1;
            route_cmd.addr   = {rider_data.station, stn_ff};
            state_in         = trla_pkg::S_ROUTE;
         end
         trla_pkg::S_ROUTE: begin
            if (func_ff == trla_pkg::FUNC_CHECK_OUT) begin
               route_cmd.wr_en = 1'b1;
               route_cmd.addr  = {rider_data.station, stn_ff};
               state_in        = trla_pkg::S_DONE;
            end else if (route_data.count == '0) begin
               state_in = trla_pkg::S_DONE;
            end else begin
               div_cmd.start = 1'b1;
               state_in      = trla_pkg::S_DIV;
            end
         end
         trla_pkg::S_DIV: begin
            if (div_res.done) begin
               found_in = 1'b1;
               if (|div_res.quotient[trla_pkg::DIVIDEND_W-1:trla_pkg::AVG_W]) begin
                  avg_in = '1;
               end else begin
                  avg_in = div_res.quotient[trla_pkg::AVG_W-1:0];
               end
               state_in = trla_pkg::S_DONE;
            end
         end
         trla_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = avg_ff;
               rsp_user_in  = {missing_ff, found_ff};
               state_in     = trla_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = trla_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trla_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      rider_ff    <= rider_in;
      stn_ff      <= stn_in;
      endst_ff    <= endst_in;
      ts_ff       <= ts_in;
      dt_ff       <= dt_in;
      avg_ff      <= avg_in;
      found_ff    <= found_in;
      missing_ff  <= missing_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### rtl/core/trla_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trla_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [trla_pkg::AVG_W-1:0]          rsp_tdata,
   input logic [trla_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   // one word in flight: no back-to-back accept
   `ASSERT_CLK(a_one_in_flight, clock, reset, (req_tvalid && req_tready) |=> !req_tready)

   // a word is never both a query hit and a missing rider
   `ASSERT_CLK(a_flags_exclusive, clock, reset, rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))

   // no average unless the route was found
   `ASSERT_CLK(a_avg_needs_found, clock, reset, (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))

   // stalled result word stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)

   // nothing offered right after reset
   `ASSERT_CLK_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid)

endmodule

bind trip_latency_route_averager_core trla_checker u_trla_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/tb_trip_latency_route_averager_core.sv
`timescale 1ns / 1ps

module tb_trip_latency_route_averager_core;

   localparam logic [trla_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 4000;
   localparam int NUM_RANDOM = 950;
   localparam int TAIL_CYCLES = 80;

   typedef struct {
      logic [trla_pkg::FUNC_W-1:0]    func;
      logic [trla_pkg::RIDER_W-1:0]   rider;
      logic [trla_pkg::STATION_W-1:0] stn;
      logic [trla_pkg::STATION_W-1:0] end_stn;
      logic [trla_pkg::TIME_W-1:0]    ts;
      int unsigned                    gap;
      bit                             hold;
   } ride_event_type;

   typedef struct packed {
      logic [trla_pkg::AVG_W-1:0] average;
      logic                       found;
      logic                       missing;
   } trip_report_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [trla_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [trla_pkg::FUNC_W-1:0]     req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [trla_pkg::AVG_W-1:0]      rsp_tdata;
   logic [trla_pkg::RSP_USER_W-1:0] rsp_tuser;

   trip_latency_route_averager_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // shadow of the rider and route tables
   bit                           rider_on    [trla_pkg::NUM_RIDERS];
   bit [trla_pkg::STATION_W-1:0] rider_from  [trla_pkg::NUM_RIDERS];
   bit [trla_pkg::TIME_W-1:0]    rider_since [trla_pkg::NUM_RIDERS];
   bit [trla_pkg::SUM_W-1:0]     route_sum   [trla_pkg::NUM_ROUTES];
   bit [trla_pkg::COUNT_W-1:0]   route_trips [trla_pkg::NUM_ROUTES];

   ride_event_type  ride_events_q[$];
   trip_report_type expected_reports_q[$];
   ride_event_type  cur_event;

   int          errors = 0;
   int          reports_seen = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   bit          long_stall_done = 0;
   bit          valid_next;
   int          idle_cycles = 0;
   logic [trla_pkg::TIME_W-1:0] now;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic apply_ride_event(input ride_event_type ev);
      trip_report_type                 rep;
      logic [trla_pkg::ROUTE_W-1:0]    rt;
      logic [trla_pkg::TIME_W-1:0]     dt;
      logic [trla_pkg::SUM_EXT_W-1:0]  ns;
      logic [trla_pkg::DIVIDEND_W-1:0] q;
      rep = '0;
      case (ev.func)
         trla_pkg::FUNC_CHECK_IN: begin
            rider_on[ev.rider]    = 1'b1;
            rider_from[ev.rider]  = ev.stn;
            rider_since[ev.rider] = ev.ts;
         end
         trla_pkg::FUNC_CHECK_OUT: begin
            if (!rider_on[ev.rider]) begin
               rep.missing = 1'b1;
            end else begin
               rider_on[ev.rider] = 1'b0;
               rt = {rider_from[ev.rider], ev.stn};
               dt = ev.ts - rider_since[ev.rider];
               ns = {1'b0, route_sum[rt]} + trla_pkg::SUM_EXT_W'(dt);
               route_sum[rt] = ns[trla_pkg::SUM_W] ? '1 : ns[trla_pkg::SUM_W-1:0];
               if (route_trips[rt] != '1) route_trips[rt] = route_trips[rt] + 1'b1;
            end
         end
         trla_pkg::FUNC_QUERY: begin
            rt = {ev.stn, ev.end_stn};
            if (route_trips[rt] != '0) begin
               q = {route_sum[rt], {trla_pkg::FRAC_W{1'b0}}} /
                   trla_pkg::DIVIDEND_W'(route_trips[rt]);
               rep.found = 1'b1;
               rep.average = (q > trla_pkg::DIVIDEND_W'(32'hFFFF_FFFF)) ? '1 :
                             q[trla_pkg::AVG_W-1:0];
            end
         end
         default: ;
      endcase
      expected_reports_q.push_back(rep);
   endtask

   task automatic add_event(input logic [trla_pkg::FUNC_W-1:0] func,
                            input logic [trla_pkg::RIDER_W-1:0] rider,
                            input logic [trla_pkg::STATION_W-1:0] stn,
                            input logic [trla_pkg::STATION_W-1:0] end_stn,
                            input logic [trla_pkg::TIME_W-1:0] ts, input int unsigned gap,
                            input bit hold);
      ride_event_type ev;
      ev.func = func;
      ev.rider = rider;
      ev.stn = stn;
      ev.end_stn = end_stn;
      ev.ts = ts;
      ev.gap = gap;
      ev.hold = hold;
      ride_events_q.push_back(ev);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 90);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         valid_next = req_tvalid;
         if (req_tvalid && req_tready) begin
            apply_ride_event(cur_event);
            valid_next = 1'b0;
         end
         if (!valid_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (ride_events_q.size() > 0 &&
                         !(ride_events_q[0].hold && expected_reports_q.size() != 0)) begin
               if (ride_events_q[0].gap != 0) begin
                  gap_left = ride_events_q[0].gap - 1;
                  ride_events_q[0].gap = 0;
               end else begin
                  cur_event = ride_events_q.pop_front();
                  valid_next = 1'b1;
                  req_tdata <= {cur_event.ts, cur_event.end_stn, cur_event.stn, cur_event.rider};
                  req_tuser <= cur_event.func;
               end
            end
         end
         req_tvalid <= valid_next;
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin : monitor
      trip_report_type want;
      int unsigned     r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            reports_seen++;
            if (expected_reports_q.size() == 0) begin
               $error("rsp word with no expected report: average %0h flags %b",
                      rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = expected_reports_q.pop_front();
               if (rsp_tdata !== want.average) begin
                  $error("average: expected %0h, got %0h", want.average, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser[0] !== want.found) begin
                  $error("route_found: expected %0b, got %0b", want.found, rsp_tuser[0]);
                  errors++;
               end
               if (rsp_tuser[1] !== want.missing) begin
                  $error("rider_missing: expected %0b, got %0b", want.missing, rsp_tuser[1]);
                  errors++;
               end
            end
         end
         // long hold-off while the sender keeps offering
         if (!long_stall_done && reports_seen >= 300) begin
            long_stall_done = 1;
            stall_left = 600;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (reports_seen >= 500 && reports_seen < 650) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               stall_left = pick_gap();
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL trip_latency_route_averager_core");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned                    r;
      logic [trla_pkg::FUNC_W-1:0]    f;
      logic [trla_pkg::RIDER_W-1:0]   rid;
      logic [trla_pkg::STATION_W-1:0] s0;
      logic [trla_pkg::STATION_W-1:0] s1;
      int unsigned                    g;

      // directed
      add_event(trla_pkg::FUNC_QUERY,     8'd0,  4'd0,  4'd0,  24'd0,      0, 1'b0);
      add_event(trla_pkg::FUNC_QUERY,     8'hFF, 4'd15, 4'd15, 24'hFFFFFF, 0, 1'b0);
      add_event(trla_pkg::FUNC_CHECK_OUT, 8'd0,  4'd0,  4'd0,  24'd0,      0, 1'b0);
      add_event(trla_pkg::FUNC_CHECK_IN,  8'd0,  4'd0,  4'd15, 24'd0,      0, 1'b0);
      add_event(trla_pkg::FUNC_CHECK_OUT, 8'd0,  4'd15, 4'd0,  24'hFFFFFF, 0, 1'b0);
      add_event(trla_pkg::FUNC_QUERY,     8'd0,  4'd0,  4'd15, 24'd0,      0, 1'b0);
      add_event(trla_pkg::FUNC_CHECK_IN,  8'hFF, 4'd15, 4'd0,  24'hFFFFFF, 0, 1'b0);
      add_event(trla_pkg::FUNC_CHECK_OUT, 8'hFF, 4'd0,  4'd15, 24'd0,      0, 1'b0);
      add_event(trla_pkg::FUNC_QUERY,     8'hFF, 4'd15, 4'd0,  24'hFFFFFF, 0, 1'b0);
      // repeated check-in overwrites the record
      add_event(trla_pkg::FUNC_CHECK_IN,  8'd7,  4'd3,  4'd0,  24'd100,    0, 1'b0);
      add_event(trla_pkg::FUNC_CHECK_IN,  8'd7,  4'd5,  4'd0,  24'd200,    0, 1'b0);
      add_event(trla_pkg::FUNC_CHECK_OUT, 8'd7,  4'd9,  4'd0,  24'd1000,   0, 1'b0);
      add_event(trla_pkg::FUNC_QUERY,     8'd0,  4'd5,  4'd9,  24'd0,      0, 1'b0);
      add_event(trla_pkg::FUNC_QUERY,     8'd0,  4'd3,  4'd9,  24'd0,      0, 1'b0);
      add_event(trla_pkg::FUNC_CHECK_OUT, 8'd7,  4'd9,  4'd0,  24'd2000,   0, 1'b0);
      // zero trip time on the same route
      add_event(trla_pkg::FUNC_CHECK_IN,  8'h80, 4'd5,  4'd0,  24'h123456, 0, 1'b0);
      add_event(trla_pkg::FUNC_CHECK_OUT, 8'h80, 4'd9,  4'd0,  24'h123456, 0, 1'b0);
      add_event(trla_pkg::FUNC_QUERY,     8'h55, 4'd5,  4'd9,  24'hAAAAAA, 0, 1'b0);
      add_event(FUNC_UNUSED,              8'hFF, 4'd15, 4'd15, 24'hFFFFFF, 0, 1'b0);
      add_event(FUNC_UNUSED,              8'd0,  4'd0,  4'd0,  24'd0,      0, 1'b0);
      add_event(trla_pkg::FUNC_QUERY,     8'd0,  4'd0,  4'd15, 24'd0,      0, 1'b0);

      // random traffic around a small set of riders and stations
      now = trla_pkg::TIME_W'($urandom());
      for (int i = 0; i < NUM_RANDOM; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) f = trla_pkg::FUNC_CHECK_IN;
         else if (r < 78) f = trla_pkg::FUNC_CHECK_OUT;
         else if (r < 96) f = trla_pkg::FUNC_QUERY;
         else f = FUNC_UNUSED;
         rid = trla_pkg::RIDER_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                              : $urandom_range(0, 11));
         s0 = trla_pkg::STATION_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                               : $urandom_range(0, 3));
         s1 = trla_pkg::STATION_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                               : $urandom_range(0, 3));
         if ($urandom_range(0, 19) == 0) now = trla_pkg::TIME_W'($urandom());
         else now = now + trla_pkg::TIME_W'($urandom_range(0, 5000));
         g = (i >= 200 && i < 350) ? 0 : pick_gap();
         add_event(f, rid, s0, s1, now, g, (i == 0 || i == 600));
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (ride_events_q.size() != 0 || req_tvalid || expected_reports_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_reports_q.size() != 0) begin
         $error("%0d expected reports never arrived", expected_reports_q.size());
         errors++;
      end
      if (errors == 0) begin
         $display("PASS trip_latency_route_averager_core");
      end else begin
         $display("FAIL trip_latency_route_averager_core");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/trla_pkg.sv
rtl/core/trla_rider_table.sv
rtl/core/trla_route_table.sv
rtl/core/trla_divider.sv
rtl/core/trip_latency_route_averager_core.sv
rtl/core/trla_checker.sv
tb/tb_trip_latency_route_averager_core.sv
